/* rtl/ckhm_pkg.sv */
`timescale 1ns / 1ps
package ckhm_pkg;

  // request modes
  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_DEL    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // hash constants
  localparam logic [31:0] MUL_X   = 32'd2147483629;
  localparam logic [31:0] MUL_Y   = 32'd4282663;
  localparam logic [31:0] MUL_MIX = 32'd277803737;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request word
    logic mix_a;   // first hash stage
    logic mix_b;   // second hash stage
    logic bucket;  // form bucket sum
    logic rcp;     // reciprocal multiply of the sum
    logic quo;     // bucket quotient
    logic rem;     // bucket index from the remainder
    logic read;    // read bucket slots
    logic commit;  // decide, write and emit result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
  } sts_t;

endpackage

/* rtl/ckhm_datapath.sv */
`timescale 1ns / 1ps
module ckhm_datapath #(
  parameter int BUCKETS = 4096,
  parameter int WAYS    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  ckhm_pkg::ctl_t ctl,
  input  ckhm_pkg::req_t req,
  output ckhm_pkg::sts_t sts,
  output ckhm_pkg::rsp_t rsp
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int IW = BW + 1;

  // bucket reduction by reciprocal: t = high word of sum * RCP,
  // q = (t + ((sum - t) >> 1)) >> (BW - 1), index = sum - q * BUCKETS
  localparam logic [63:0] RCP_FULL =
    ((((64'd1 << BW) - 64'(BUCKETS)) << 32) / 64'(BUCKETS)) + 64'd1;
  localparam logic [31:0] RCP = RCP_FULL[31:0];

  // one row per bucket, one lane per way
  logic [WAYS-1:0]   valid_mem [BUCKETS];
  logic [31:0]       kx_mem [BUCKETS][WAYS];
  logic [31:0]       ky_mem [BUCKETS][WAYS];
  logic [31:0]       val_mem [BUCKETS][WAYS];

  ckhm_pkg::req_t    r;
  logic [31:0]       sx, sy, tx, ty, sum;
  logic [31:0]       rt, quo;
  logic [BW-1:0]     bidx;
  logic [WAYS-1:0]   rd_valid;
  logic [31:0]       rd_kx [WAYS];
  logic [31:0]       rd_ky [WAYS];
  logic [31:0]       rd_val [WAYS];
  logic [IW-1:0]     clr_idx;
  logic              clearing;

  // xor-shift step before the mix multiply
  function automatic logic [31:0] xsh(input logic [31:0] s);
    logic [4:0] sh;
    sh = {1'b0, s[31:28]} + 5'd4;
    return (s >> sh) ^ s;
  endfunction

  // hash: multiply, xor-shift + multiply, fold + add, then bucket reduction
  always_ff @(posedge clk) begin
    if (ctl.load) r <= req;
    if (ctl.mix_a) begin
      sx <= r.key_x * ckhm_pkg::MUL_X;
      sy <= r.key_y * ckhm_pkg::MUL_Y;
    end
    if (ctl.mix_b) begin
      tx <= xsh(sx) * ckhm_pkg::MUL_MIX;
      ty <= xsh(sy) * ckhm_pkg::MUL_MIX;
    end
    if (ctl.bucket) begin
      sum <= ((tx >> 22) ^ tx) + ((ty >> 22) ^ ty);
    end
    if (ctl.rcp) rt <= 32'((64'(sum) * 64'(RCP)) >> 32);
    if (ctl.quo) quo <= (rt + ((sum - rt) >> 1)) >> (BW - 1);
    if (ctl.rem) bidx <= BW'(sum - quo * 32'(BUCKETS));
  end

  // registered bucket read
  always_ff @(posedge clk) begin
    if (ctl.read) begin
      rd_valid <= valid_mem[bidx];
      rd_kx    <= kx_mem[bidx];
      rd_ky    <= ky_mem[bidx];
      rd_val   <= val_mem[bidx];
    end
  end

  // slot search over the fetched row
  logic            hit, have_free;
  logic [WW-1:0]   hit_w, free_w;
  always_comb begin
    hit = 1'b0;
    have_free = 1'b0;
    hit_w = '0;
    free_w = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_valid[w]) begin
        if (!hit && rd_kx[w] == r.key_x && rd_ky[w] == r.key_y) begin
          hit = 1'b1;
          hit_w = WW'(w);
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_w = WW'(w);
      end
    end
  end

  // clearing pass over valid rows after reset
  assign clearing = !clr_idx[IW-1] || (clr_idx[BW-1:0] != BW'(BUCKETS - 1));
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      sts.clear_done <= 1'b0;
    end else if (!sts.clear_done) begin
      if (clr_idx == IW'(BUCKETS - 1)) sts.clear_done <= 1'b1;
      else clr_idx <= clr_idx + IW'(1);
    end
  end

  // valid row write: clear sweep or commit
  always_ff @(posedge clk) begin
    if (!sts.clear_done) begin
      valid_mem[clr_idx[BW-1:0]] <= '0;
    end else if (ctl.commit) begin
      if (r.mode == ckhm_pkg::MODE_SET && !hit && have_free) begin
        valid_mem[bidx] <= rd_valid | (WAYS'(1) << free_w);
      end else if (r.mode == ckhm_pkg::MODE_DEL && hit) begin
        valid_mem[bidx] <= rd_valid & ~(WAYS'(1) << hit_w);
      end
    end
  end

  // key and value write
  always_ff @(posedge clk) begin
    if (ctl.commit && r.mode == ckhm_pkg::MODE_SET) begin
      if (hit) begin
        val_mem[bidx][hit_w] <= r.new_value;
      end else if (have_free) begin
        kx_mem[bidx][free_w]  <= r.key_x;
        ky_mem[bidx][free_w]  <= r.key_y;
        val_mem[bidx][free_w] <= r.new_value;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp.read_value <= '0;
      case (r.mode)
        ckhm_pkg::MODE_SET: rsp.status <= (hit || have_free) ? ckhm_pkg::ST_OK
                                                              : ckhm_pkg::ST_FULL;
        ckhm_pkg::MODE_GET: begin
          rsp.status <= hit ? ckhm_pkg::ST_OK : ckhm_pkg::ST_ABSENT;
          if (hit) rsp.read_value <= rd_val[hit_w];
        end
        ckhm_pkg::MODE_DEL: rsp.status <= hit ? ckhm_pkg::ST_OK : ckhm_pkg::ST_ABSENT;
        default: rsp.status <= ckhm_pkg::ST_ABSENT;
      endcase
    end
  end

`ifndef SYNTHESIS
  // sweep index stays in range while clearing
  a_clr_range: assert property (@(posedge clk) disable iff (rst)
    !sts.clear_done |-> (clr_idx < IW'(BUCKETS)))
    else $error("clear index out of range");
  // clearing ends only at the last row
  a_clr_end: assert property (@(posedge clk) disable iff (rst)
    $rose(sts.clear_done) |-> $past(clr_idx == IW'(BUCKETS - 1)))
    else $error("clear pass ended early");
  // no commit during the clearing pass
  a_no_commit: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> sts.clear_done)
    else $error("commit while clearing");
  // clearing flag consistent with done
  a_clr_flag: assert property (@(posedge clk) disable iff (rst)
    sts.clear_done |-> !clearing || clr_idx == IW'(BUCKETS - 1))
    else $error("clear flag mismatch");
`endif

endmodule

/* rtl/ckhm_ctrl.sv */
`timescale 1ns / 1ps
module ckhm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ckhm_pkg::sts_t sts,
  output logic           busy,
  output logic           done,
  output ckhm_pkg::ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE, S_MIXA, S_MIXB, S_BKT, S_RCP, S_QUO, S_REM, S_READ, S_COMMIT
  } state_t;

  state_t state;

  // command decode: load from start and busy, the rest from state
  always_comb begin
    ctl = '0;
    ctl.load   = start && !busy;
    ctl.mix_a  = (state == S_MIXA);
    ctl.mix_b  = (state == S_MIXB);
    ctl.bucket = (state == S_BKT);
    ctl.rcp    = (state == S_RCP);
    ctl.quo    = (state == S_QUO);
    ctl.rem    = (state == S_REM);
    ctl.read   = (state == S_READ);
    ctl.commit = (state == S_COMMIT);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!sts.clear_done) begin
            busy <= 1'b1;
          end else if (start && !busy) begin
            state <= S_MIXA;
            busy  <= 1'b1;
          end else begin
            busy <= 1'b0;
          end
        end
        S_MIXA:   state <= S_MIXB;
        S_MIXB:   state <= S_BKT;
        S_BKT:    state <= S_RCP;
        S_RCP:    state <= S_QUO;
        S_QUO:    state <= S_REM;
        S_REM:    state <= S_READ;
        S_READ:   state <= S_COMMIT;
        S_COMMIT: begin
          state <= S_IDLE;
          done  <= 1'b1;
          busy  <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result follows every commit
  a_done: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> done)
    else $error("missing result strobe");
  // no acceptance while a request is in flight
  a_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> state == S_IDLE && sts.clear_done)
    else $error("accept outside idle");
  // the strobe is one cycle
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe too long");
`endif

endmodule

/* rtl/coordinate_keyed_hash_map.sv */
`timescale 1ns / 1ps
// After the accepting edge a request passes MIXA, MIXB, BKT, RCP, QUO, REM, READ and
// COMMIT: the two-stage hash, the three-step reciprocal bucket reduction and the bucket
// row read. done and the result word are registered in COMMIT; busy falls with done, so
// no new request is taken before the last one is through. Reset: synchronous rst;
// afterwards busy stays high while the valid rows are swept clear, one row per cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
module coordinate_keyed_hash_map #(
  parameter int BUCKETS = 4096,
  parameter int WAYS    = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ckhm_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output ckhm_pkg::rsp_t rsp
);

  ckhm_pkg::ctl_t ctl;
  ckhm_pkg::sts_t sts;

  ckhm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts),
    .busy(busy), .done(done), .ctl(ctl)
  );

  ckhm_datapath #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .req(req), .sts(sts), .rsp(rsp)
  );

endmodule
